FILE: hdl/tocnt_pkg.sv
// Package for the tag occurrence counter table.
// Field widths, table depth default and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package tocnt_pkg;

  // Default number of slots in each direction's table
  localparam int unsigned TableEntriesDef = 64;

  // Fixed field widths
  localparam int unsigned TagW = 31;
  localparam int unsigned CntW = 32;
  localparam int unsigned WordW = TagW + CntW;

  // Direction codes
  localparam logic DirSend = 1'b0;
  localparam logic DirRecv = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  // One stored slot: tag and occurrence count
  typedef struct packed {
    logic [TagW-1:0] tag;
    logic [CntW-1:0] count;
  } slot_t;

endpackage

FILE: hdl/tag_occurrence_counter_table_top.sv
// Tag occurrence counter table: top level with the slot memory and scan sequencer.
// Depends on tocnt_pkg.
`timescale 1ns / 1ps

// Usage:
// Input channel (in_valid_i / in_stall_o) carries one beat per lookup: a
// direction (0 send, 1 receive) and a 31-bit tag. Output channel
// (out_valid_o / out_stall_i) returns exactly one beat per lookup: the
// updated occurrence count (saturating at all ones) and table_full_o, set
// with a count of 0 when the tag is absent and every slot is taken.
// Both tables live in one synchronous memory, one half per direction.
// Slots fill strictly in order, so a per-direction fill count marks which
// slots are valid. A lookup reads slots 0..fill-1 in order, stopping at a
// match, one read per cycle, comparing each the cycle after its read, then
// writes back at most once. One lookup is in flight at a time. A finished
// result sits in an output register, so the next beat is accepted while it
// waits; if the receiver still stalls when the next lookup finishes, that
// lookup holds.
// Reset clears the fill counts (both tables empty) and the handshake state.
module tag_occurrence_counter_table_top
  import tocnt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // Lookup beats
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            direction_i,
  input  logic [TagW-1:0] tag_i,
  // Result beats
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [CntW-1:0] occurrence_o,
  output logic            table_full_o
);

  localparam int unsigned SlotW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned FillW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned AddrW = SlotW + 1;
  localparam int unsigned Depth = 2 ** AddrW;
  localparam logic [FillW-1:0] FillMax = FillW'(TABLE_ENTRIES);

  state_e state_q, state_d;

  logic             dir_q;
  logic [TagW-1:0]  tag_q;
  logic [FillW-1:0] idx_q, idx_d;
  logic             chk_vld_q, chk_vld_d;
  logic [SlotW-1:0] chk_idx_q;
  logic [FillW-1:0] fill_q [2];
  logic [FillW-1:0] fill_sel;

  slot_t            mem [Depth];
  slot_t            rd_data_q;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  slot_t            wr_data;

  logic             res_vld_q, res_vld_d;
  logic [CntW-1:0]  res_cnt_q;
  logic             res_full_q;

  logic             in_acc;
  logic             hit, exhausted, done, out_free, finish, claim;
  logic [CntW-1:0]  cnt_inc;
  logic [CntW-1:0]  new_cnt;
  logic             new_full;

  assign in_acc   = in_valid_i & ~in_stall_o;
  assign fill_sel = fill_q[dir_q];
  assign out_free = ~res_vld_q | ~out_stall_i;

  // Scan decisions: compare the slot read last cycle, or notice the end
  assign hit       = chk_vld_q & (rd_data_q.tag == tag_q);
  assign exhausted = (idx_q == fill_sel);
  assign done      = (state_q == ST_SCAN) & (hit | exhausted);
  assign finish    = done & out_free;
  assign claim     = finish & ~hit & (fill_sel != FillMax);

  // Saturating increment of the matched count
  assign cnt_inc = (rd_data_q.count == '1) ? rd_data_q.count : rd_data_q.count + CntW'(1);

  always_comb begin
    if (hit) begin
      new_cnt  = cnt_inc;
      new_full = 1'b0;
    end else if (fill_sel != FillMax) begin
      new_cnt  = CntW'(1);
      new_full = 1'b0;
    end else begin
      new_cnt  = '0;
      new_full = 1'b1;
    end
  end

  // Memory port control
  assign rd_en   = (state_q == ST_SCAN) & ~done;
  assign rd_addr = {dir_q, idx_q[SlotW-1:0]};
  assign wr_en   = finish & ~new_full;
  assign wr_addr = hit ? {dir_q, chk_idx_q} : {dir_q, fill_sel[SlotW-1:0]};
  assign wr_data = '{tag: tag_q, count: new_cnt};

  // Slot memory, one read and one write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Sequencer next state
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    chk_vld_d = chk_vld_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d   = ST_SCAN;
          idx_d     = '0;
          chk_vld_d = 1'b0;
        end
      end
      ST_SCAN: begin
        if (finish) begin
          state_d   = ST_IDLE;
          chk_vld_d = 1'b0;
        end else if (!done) begin
          idx_d     = idx_q + FillW'(1);
          chk_vld_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      chk_vld_q <= 1'b0;
      fill_q[0] <= '0;
      fill_q[1] <= '0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      chk_vld_q <= chk_vld_d;
      if (claim) begin
        fill_q[dir_q] <= fill_sel + FillW'(1);
      end
    end
  end

  // Lookup beat capture and compare slot tracking
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dir_q <= direction_i;
      tag_q <= tag_i;
    end
    if (rd_en) begin
      chk_idx_q <= idx_q[SlotW-1:0];
    end
  end

  // Result register
  always_comb begin
    res_vld_d = res_vld_q;
    if (finish) begin
      res_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      res_cnt_q  <= new_cnt;
      res_full_q <= new_full;
    end
  end

  assign out_valid_o  = res_vld_q;
  assign occurrence_o = res_cnt_q;
  assign table_full_o = res_full_q;

  // Checks
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_full_o |-> occurrence_o == '0)
    else $error("full result with nonzero count");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !table_full_o |-> occurrence_o != '0)
    else $error("zero count without full flag");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q[0] <= FillMax && fill_q[1] <= FillMax)
    else $error("fill count beyond table depth");

  a_check_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN && chk_vld_q |-> {1'b0, chk_idx_q} < {1'b0, fill_sel})
    else $error("compared a slot that was never filled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("lookup accepted while another was in flight");

endmodule

FILE: sim/tb_tag_occurrence_counter_table_top.sv
// Self-checking testbench for the tag occurrence counter table: a driver, a result monitor
// and a scoreboard that predicts the count or full flag for each lookup.
// Depends on tocnt_pkg and tag_occurrence_counter_table_top.
`timescale 1ns / 1ps

module tb_tag_occurrence_counter_table_top;
  import tocnt_pkg::*;

  localparam int unsigned Entries = TableEntriesDef;
  localparam int unsigned ClkHalf = 10;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned ReportMax = 10;

  typedef struct packed {
    logic            dir;
    logic [TagW-1:0] tag;
  } lookup_t;

  typedef struct packed {
    logic [CntW-1:0] occurrence;
    logic            table_full;
  } count_result_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic            direction_i = DirSend;
  logic [TagW-1:0] tag_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [CntW-1:0] occurrence_o;
  logic            table_full_o;

  tag_occurrence_counter_table_top #(
    .TABLE_ENTRIES(Entries)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .direction_i (direction_i),
    .tag_i       (tag_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .occurrence_o(occurrence_o),
    .table_full_o(table_full_o)
  );

  // Lookups waiting to be driven, and counts waiting to come back
  lookup_t       lookups_pending[$];
  count_result_t counts_expected[$];

  // Tags issued so far per direction; repeats weight hot tags
  logic [TagW-1:0] send_tags_issued[$];
  logic [TagW-1:0] recv_tags_issued[$];

  // Traffic shape, changed between phases
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned new_tag_pct = 15;

  // Mirror of both tag tables
  logic [TagW-1:0] slot_tag[2][Entries];
  logic [CntW-1:0] slot_count[2][Entries];
  int unsigned     slot_fill[2] = '{0, 0};

  int unsigned mismatches = 0;
  int unsigned counts_checked = 0;
  int unsigned full_seen = 0;
  logic [CntW-1:0] top_count = '0;
  int unsigned idle_cycles = 0;

  // Scan the mirrored table in slot order: bump on match, claim first empty slot
  function automatic count_result_t count_lookup(logic dir, logic [TagW-1:0] tag);
    count_result_t res;
    res.occurrence = '0;
    res.table_full = 1'b1;
    for (int unsigned s = 0; s < slot_fill[dir]; s++) begin
      if (slot_tag[dir][s] == tag) begin
        if (slot_count[dir][s] != '1) slot_count[dir][s] = slot_count[dir][s] + 1'b1;
        res.occurrence = slot_count[dir][s];
        res.table_full = 1'b0;
        return res;
      end
    end
    if (slot_fill[dir] < Entries) begin
      slot_tag[dir][slot_fill[dir]] = tag;
      slot_count[dir][slot_fill[dir]] = 1;
      slot_fill[dir] = slot_fill[dir] + 1;
      res.occurrence = 1;
      res.table_full = 1'b0;
    end
    return res;
  endfunction

  // Clock
  initial begin
    forever #ClkHalf clk_i = ~clk_i;
  end

  // Driver: predict on each accepted beat, then present the next lookup or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        counts_expected.push_back(count_lookup(direction_i, tag_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (lookups_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i  <= 1'b1;
          direction_i <= lookups_pending[0].dir;
          tag_i       <= lookups_pending[0].tag;
          void'(lookups_pending.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest expected count
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (counts_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportMax)
            $display("result beat with nothing expected: occurrence %0d full %0b",
                     occurrence_o, table_full_o);
        end else begin
          if (counts_expected[0].occurrence !== occurrence_o ||
              counts_expected[0].table_full !== table_full_o) begin
            mismatches++;
            if (mismatches <= ReportMax)
              $display("result %0d: expected occurrence %0d full %0b, got occurrence %0d full %0b",
                       counts_checked, counts_expected[0].occurrence,
                       counts_expected[0].table_full, occurrence_o, table_full_o);
          end
          if (counts_expected[0].table_full) full_seen++;
          if (counts_expected[0].occurrence > top_count) top_count = counts_expected[0].occurrence;
          counts_checked++;
          void'(counts_expected.pop_front());
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: ends the run when no beat moves on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no beat moved for %0d cycles", IdleLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic add_lookup(logic dir, logic [TagW-1:0] tag);
    lookup_t lk;
    lk.dir = dir;
    lk.tag = tag;
    lookups_pending.push_back(lk);
    if (dir == DirRecv) recv_tags_issued.push_back(tag);
    else send_tags_issued.push_back(tag);
  endtask

  // Random lookups: mostly tags already seen in that direction, some new ones
  task automatic add_random_lookups(int unsigned n);
    logic            dir;
    logic [TagW-1:0] tag;
    int unsigned     known;
    repeat (n) begin
      dir = 1'($urandom_range(1));
      known = (dir == DirRecv) ? recv_tags_issued.size() : send_tags_issued.size();
      if (known != 0 && $urandom_range(99) >= new_tag_pct) begin
        tag = (dir == DirRecv) ? recv_tags_issued[$urandom_range(known - 1)]
                               : send_tags_issued[$urandom_range(known - 1)];
      end else begin
        case ($urandom_range(3))
          0, 1:    tag = TagW'($urandom());
          2:       tag = TagW'($urandom_range(15));
          default: tag = '1 - TagW'($urandom_range(15));
        endcase
      end
      add_lookup(dir, tag);
    end
  endtask

  // Hold off until every queued lookup has gone in and its count has come back
  task automatic wait_drained();
    while (lookups_pending.size() != 0 || in_valid_i || counts_expected.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extreme tags, repeats, same tag in both tables
    add_lookup(DirSend, '0);
    add_lookup(DirSend, '0);
    add_lookup(DirRecv, '0);
    add_lookup(DirSend, '1);
    add_lookup(DirRecv, '1);
    add_lookup(DirSend, '0);
    add_lookup(DirRecv, '1);
    add_lookup(DirSend, 31'h0000_0001);
    add_lookup(DirSend, 31'h0000_0002);
    add_lookup(DirRecv, 31'h4000_0000);
    add_lookup(DirRecv, 31'h5555_5555);
    add_lookup(DirSend, 31'h2AAA_AAAA);
    add_lookup(DirSend, 31'h5555_5555);
    add_lookup(DirRecv, 31'h2AAA_AAAA);
    add_lookup(DirSend, 31'h0000_0001);
    add_lookup(DirRecv, 31'h0000_0001);
    add_lookup(DirSend, 31'h7FFF_FFFE);
    add_lookup(DirRecv, '0);
    add_lookup(DirSend, '1);
    add_lookup(DirRecv, 31'h4000_0000);

    // Back to back, no stalls
    new_tag_pct = 12;
    add_random_lookups(180);
    wait_drained();

    // Sparse sender
    send_idle_pct = 85;
    new_tag_pct = 15;
    add_random_lookups(240);
    wait_drained();

    // Slow receiver
    send_idle_pct = 0;
    recv_stall_pct = 85;
    add_random_lookups(240);
    wait_drained();

    // Light gaps on both sides
    send_idle_pct = 20;
    recv_stall_pct = 20;
    new_tag_pct = 20;
    add_random_lookups(240);
    wait_drained();

    // Full speed again, many new tags so both tables run out of slots
    send_idle_pct = 0;
    recv_stall_pct = 0;
    new_tag_pct = 45;
    add_random_lookups(230);
    wait_drained();

    repeat (Entries + 4) @(posedge clk_i);

    $display("Checked %0d lookups across five gap/stall patterns;", counts_checked);
    $display("%0d found a full table, top count %0d; slots claimed: send %0d, receive %0d of %0d.",
             full_seen, top_count, slot_fill[DirSend], slot_fill[DirRecv], Entries);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatching result beats", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
